@@ src/qnu_pkg.sv @@
// qnu_pkg: shared types and constants for the quaternion normalizer unit
// no dependencies

package qnu_pkg;

    localparam int unsigned LANES           = 4;
    localparam int unsigned COMP_W          = 16;
    localparam int unsigned SQ_W            = 32;
    localparam int unsigned SUM_W           = 34;
    localparam int unsigned ROOT_W          = 17;
    localparam int unsigned REM_W           = 19;
    localparam int unsigned OUT_FRAC_BITS_D = 14;

    typedef struct packed {
        logic              neg;
        logic [COMP_W-1:0] mag;
    } t_lane;

    typedef struct packed {
        logic              valid;
        logic [SUM_W-1:0]  n;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
        t_lane [LANES-1:0] lanes;
    } t_sq;

endpackage

@@ src/qnu_in_if.sv @@
// qnu_in_if: input channel carrying one quaternion per item
// depends on qnu_pkg

interface qnu_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [qnu_pkg::COMP_W-1:0]   comp_x;
    logic signed [qnu_pkg::COMP_W-1:0]   comp_y;
    logic signed [qnu_pkg::COMP_W-1:0]   comp_z;
    logic signed [qnu_pkg::COMP_W-1:0]   comp_w;

    modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
    modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

@@ src/qnu_out_if.sv @@
// qnu_out_if: output channel carrying one normalized quaternion per item
// depends on qnu_pkg

interface qnu_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [qnu_pkg::COMP_W-1:0]   unit_x;
    logic signed [qnu_pkg::COMP_W-1:0]   unit_y;
    logic signed [qnu_pkg::COMP_W-1:0]   unit_z;
    logic signed [qnu_pkg::COMP_W-1:0]   unit_w;
    logic        [qnu_pkg::ROOT_W-1:0]   length;
    logic                                zero_input;

    modport source (output valid, unit_x, unit_y, unit_z, unit_w, length, zero_input,
                    input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, length, zero_input,
                    output ready);
endinterface

@@ src/qnu_sqrt_cell.sv @@
// qnu_sqrt_cell: one root digit of the square root chain, registered
// depends on qnu_pkg

module qnu_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  qnu_pkg::t_sq   i_d,
    output qnu_pkg::t_sq   o_d
);
    logic [qnu_pkg::REM_W+1:0] t;
    logic [qnu_pkg::REM_W-1:0] trial;
    qnu_pkg::t_sq              n_d;
    qnu_pkg::t_sq              r_d;

    always_comb begin
        t     = {i_d.rem, i_d.n[qnu_pkg::SUM_W-1 -: 2]};
        trial = {i_d.root[qnu_pkg::REM_W-3:0], 2'b01};
        n_d   = i_d;
        n_d.n = {i_d.n[qnu_pkg::SUM_W-3:0], 2'b00};
        if (t >= {2'b00, trial}) begin
            n_d.rem  = qnu_pkg::REM_W'(t - {2'b00, trial});
            n_d.root = {i_d.root[qnu_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_d.rem  = t[qnu_pkg::REM_W-1:0];
            n_d.root = {i_d.root[qnu_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d.valid <= n_d.valid;
        end
        if (i_en) begin
            r_d.n     <= n_d.n;
            r_d.root  <= n_d.root;
            r_d.rem   <= n_d.rem;
            r_d.lanes <= n_d.lanes;
        end
    end

    assign o_d = r_d;
endmodule

@@ src/qnu_div_cell.sv @@
// qnu_div_cell: one quotient bit for all four lanes of the divide chain, registered
// depends on qnu_pkg

module qnu_div_cell #(
    parameter int unsigned QW = qnu_pkg::OUT_FRAC_BITS_D + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [qnu_pkg::ROOT_W-1:0]  i_mag,
    input  logic [qnu_pkg::LANES-1:0]   i_neg,
    input  logic [qnu_pkg::ROOT_W-1:0]  i_rem  [qnu_pkg::LANES],
    input  logic [QW-1:0]               i_bits [qnu_pkg::LANES],
    input  logic [QW-1:0]               i_quo  [qnu_pkg::LANES],
    output logic                        o_valid,
    output logic [qnu_pkg::ROOT_W-1:0]  o_mag,
    output logic [qnu_pkg::LANES-1:0]   o_neg,
    output logic [qnu_pkg::ROOT_W-1:0]  o_rem  [qnu_pkg::LANES],
    output logic [QW-1:0]               o_bits [qnu_pkg::LANES],
    output logic [QW-1:0]               o_quo  [qnu_pkg::LANES]
);
    logic [qnu_pkg::ROOT_W:0]   t      [qnu_pkg::LANES];
    logic [qnu_pkg::ROOT_W-1:0] n_rem  [qnu_pkg::LANES];
    logic [QW-1:0]              n_quo  [qnu_pkg::LANES];
    logic                       r_valid;
    logic [qnu_pkg::ROOT_W-1:0] r_mag;
    logic [qnu_pkg::LANES-1:0]  r_neg;
    logic [qnu_pkg::ROOT_W-1:0] r_rem  [qnu_pkg::LANES];
    logic [QW-1:0]              r_bits [qnu_pkg::LANES];
    logic [QW-1:0]              r_quo  [qnu_pkg::LANES];

    always_comb begin
        for (int i = 0; i < qnu_pkg::LANES; i++) begin
            t[i] = {i_rem[i], i_bits[i][QW-1]};
            if (t[i] >= {1'b0, i_mag}) begin
                n_rem[i] = qnu_pkg::ROOT_W'(t[i] - {1'b0, i_mag});
                n_quo[i] = {i_quo[i][QW-2:0], 1'b1};
            end else begin
                n_rem[i] = t[i][qnu_pkg::ROOT_W-1:0];
                n_quo[i] = {i_quo[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_mag <= i_mag;
            r_neg <= i_neg;
            for (int i = 0; i < qnu_pkg::LANES; i++) begin
                r_rem[i]  <= n_rem[i];
                r_bits[i] <= {i_bits[i][QW-2:0], 1'b0};
                r_quo[i]  <= n_quo[i];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;
    assign o_rem   = r_rem;
    assign o_bits  = r_bits;
    assign o_quo   = r_quo;
endmodule

@@ src/quaternion_normalizer_unit.sv @@
// quaternion_normalizer_unit: top level, squares, sum, root chain, divide chain, output
// depends on qnu_pkg, qnu_in_if, qnu_out_if, qnu_sqrt_cell, qnu_div_cell

// Takes one quaternion item per cycle while the output is not stalled and
// returns its unit quaternion in signed Q1.OUT_FRAC_BITS plus the
// floor-root magnitude. Fully pipelined: a new item is accepted every
// cycle unless the output stalls. Each item passes the squares stage, the
// sum stage, the one-digit-per-cell square root chain, the
// one-bit-per-cell divide chain and the output register. A stall on the
// output holds the whole pipeline. A zero quaternion gives zero
// components and sets zero_input.

module quaternion_normalizer_unit #(
    parameter int unsigned OUT_FRAC_BITS = qnu_pkg::OUT_FRAC_BITS_D
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qnu_in_if.sink    i_in,
    qnu_out_if.source o_out
);
    localparam int unsigned QW    = OUT_FRAC_BITS + 1;
    localparam int unsigned NSQ   = qnu_pkg::ROOT_W;
    localparam logic [QW-1:0] ONE = QW'(1) << OUT_FRAC_BITS;

    logic                                en;
    logic signed [qnu_pkg::COMP_W-1:0]   comp [qnu_pkg::LANES];
    logic                                r_s1_valid;
    qnu_pkg::t_lane [qnu_pkg::LANES-1:0] r_s1_lanes;
    logic [qnu_pkg::SQ_W-1:0]            r_s1_sq [qnu_pkg::LANES];
    qnu_pkg::t_sq                        r_s2;
    qnu_pkg::t_sq                        sq [NSQ+1];

    logic                        dv_valid [QW+1];
    logic [qnu_pkg::ROOT_W-1:0]  dv_mag   [QW+1];
    logic [qnu_pkg::LANES-1:0]   dv_neg   [QW+1];
    logic [qnu_pkg::ROOT_W-1:0]  dv_rem   [QW+1][qnu_pkg::LANES];
    logic [QW-1:0]               dv_bits  [QW+1][qnu_pkg::LANES];
    logic [QW-1:0]               dv_quo   [QW+1][qnu_pkg::LANES];

    logic [QW-1:0]                       qc   [qnu_pkg::LANES];
    logic [qnu_pkg::COMP_W-1:0]          n_u  [qnu_pkg::LANES];
    logic                                r_out_valid;
    logic [qnu_pkg::COMP_W-1:0]          r_u  [qnu_pkg::LANES];
    logic [qnu_pkg::ROOT_W-1:0]          r_len;
    logic                                r_zero;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;
    assign comp[0]    = i_in.comp_x;
    assign comp[1]    = i_in.comp_y;
    assign comp[2]    = i_in.comp_z;
    assign comp[3]    = i_in.comp_w;

    // squares and magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in.valid;
        end
        if (en) begin
            for (int i = 0; i < qnu_pkg::LANES; i++) begin
                r_s1_sq[i]        <= qnu_pkg::SQ_W'(comp[i] * comp[i]);
                r_s1_lanes[i].neg <= comp[i][qnu_pkg::COMP_W-1];
                r_s1_lanes[i].mag <= comp[i][qnu_pkg::COMP_W-1]
                                     ? qnu_pkg::COMP_W'(-comp[i])
                                     : qnu_pkg::COMP_W'(comp[i]);
            end
        end
    end

    // sum of squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (en) begin
            r_s2.valid <= r_s1_valid;
        end
        if (en) begin
            r_s2.n     <= qnu_pkg::SUM_W'(r_s1_sq[0]) + qnu_pkg::SUM_W'(r_s1_sq[1])
                        + qnu_pkg::SUM_W'(r_s1_sq[2]) + qnu_pkg::SUM_W'(r_s1_sq[3]);
            r_s2.root  <= '0;
            r_s2.rem   <= '0;
            r_s2.lanes <= r_s1_lanes;
        end
    end

    assign sq[0] = r_s2;

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        qnu_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (sq[k]),
            .o_d     (sq[k+1])
        );
    end

    assign dv_valid[0] = sq[NSQ].valid;
    assign dv_mag[0]   = sq[NSQ].root;
    for (genvar i = 0; i < qnu_pkg::LANES; i++) begin : g_seed
        assign dv_neg[0][i]  = sq[NSQ].lanes[i].neg;
        assign dv_rem[0][i]  = {2'b00, sq[NSQ].lanes[i].mag[qnu_pkg::COMP_W-1:1]};
        assign dv_bits[0][i] = {sq[NSQ].lanes[i].mag[0], {(QW-1){1'b0}}};
        assign dv_quo[0][i]  = '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        qnu_div_cell #(.QW(QW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[k]),
            .i_mag   (dv_mag[k]),
            .i_neg   (dv_neg[k]),
            .i_rem   (dv_rem[k]),
            .i_bits  (dv_bits[k]),
            .i_quo   (dv_quo[k]),
            .o_valid (dv_valid[k+1]),
            .o_mag   (dv_mag[k+1]),
            .o_neg   (dv_neg[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_bits  (dv_bits[k+1]),
            .o_quo   (dv_quo[k+1])
        );
    end

    // saturate, sign and zero case
    always_comb begin
        for (int i = 0; i < qnu_pkg::LANES; i++) begin
            qc[i] = (dv_quo[QW][i] > ONE) ? ONE : dv_quo[QW][i];
            if (dv_mag[QW] == '0) begin
                n_u[i] = '0;
            end else if (dv_neg[QW][i]) begin
                n_u[i] = qnu_pkg::COMP_W'(-{{(qnu_pkg::COMP_W - QW){1'b0}}, qc[i]});
            end else begin
                n_u[i] = qnu_pkg::COMP_W'({{(qnu_pkg::COMP_W - QW){1'b0}}, qc[i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid[QW];
        end
        if (en) begin
            r_u    <= n_u;
            r_len  <= dv_mag[QW];
            r_zero <= (dv_mag[QW] == '0);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.unit_x     = r_u[0];
    assign o_out.unit_y     = r_u[1];
    assign o_out.unit_z     = r_u[2];
    assign o_out.unit_w     = r_u[3];
    assign o_out.length     = r_len;
    assign o_out.zero_input = r_zero;

`ifndef SYNTHESIS
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("ready does not follow output stall");
    a_zero_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.zero_input) |->
        (o_out.unit_x == 0 && o_out.unit_w == 0 && o_out.length == 0))
        else $error("zero item with nonzero outputs");
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.zero_input) |-> (o_out.length != 0))
        else $error("nonzero item with zero length");
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ($signed(o_out.unit_x) <= $signed(16'sd16384)
                      && $signed(o_out.unit_x) >= -$signed(16'sd16384)))
        else $error("unit_x out of range");
`endif
endmodule
